[rtl/aoit_pkg.sv]
// Shared types and constants of the AXI outstanding ID tracker.
`timescale 1ns / 1ps

package aoit_pkg;

  localparam int ACTION_W            = 3;
  localparam int TXN_ID_W            = 8;
  localparam int DATA_W              = 64;
  localparam int CAP_W               = 5;
  localparam int CAP_RESET           = 16;
  localparam int MAX_OUTSTANDING_DEF = 16;
  localparam int ID_BITS_DEF         = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ISSUE_WR  = 3'd0,
    ACT_ISSUE_RD  = 3'd1,
    ACT_CMPL_WR   = 3'd2,
    ACT_READ_BEAT = 3'd3,
    ACT_LOOKUP    = 3'd4,
    ACT_CLEAR     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic exec;     // apply the latched word and load the result register
    logic sweep;    // write one zero entry of the data store
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // result register can take a new word this cycle
    logic is_clear;    // latched word is a clear
    logic sweep_last;  // sweep address at the last entry
  } dp_stat_t;

endpackage

[rtl/aoit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module aoit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/aoit_ctrl.sv]
// Sequencing state machine of the tracker: sweep, accept, execute.
`timescale 1ns / 1ps

module aoit_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  aoit_pkg::dp_stat_t  stat,
  output logic                in_stall,
  output aoit_pkg::ctrl_cmd_t cmd
);

  aoit_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aoit_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aoit_pkg::ST_SWEEP: begin
        if (stat.sweep_last) state_next = aoit_pkg::ST_IDLE;
      end
      aoit_pkg::ST_IDLE: begin
        if (in_valid) state_next = aoit_pkg::ST_EXEC;
      end
      aoit_pkg::ST_EXEC: begin
        if (stat.out_free) begin
          state_next = stat.is_clear ? aoit_pkg::ST_SWEEP : aoit_pkg::ST_IDLE;
        end
      end
      default: state_next = aoit_pkg::ST_SWEEP;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.sweep   = 1'b0;
    unique case (state)
      aoit_pkg::ST_SWEEP: cmd.sweep = 1'b1;
      aoit_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      aoit_pkg::ST_EXEC: cmd.exec = stat.out_free;
      default: ;
    endcase
  end

`ifndef SYNTH
  // a clear always leads into a sweep of the data store
  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && stat.is_clear) |=> (state == aoit_pkg::ST_SWEEP))
    else $error("clear did not start a sweep");
  // every captured word is executed in the following state
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == aoit_pkg::ST_EXEC))
    else $error("captured word not taken to execute");
`endif

endmodule

[rtl/aoit_dpath.sv]
// Datapath of the tracker: ID pools, counters, data store and result register.
`timescale 1ns / 1ps

module aoit_dpath #(
  parameter int MAX_OUTSTANDING = aoit_pkg::MAX_OUTSTANDING_DEF,
  parameter int ID_BITS         = aoit_pkg::ID_BITS_DEF,
  localparam int CNT_W          = $clog2(MAX_OUTSTANDING + 1),
  localparam int CMP_W          = (CNT_W > aoit_pkg::CAP_W) ? CNT_W : aoit_pkg::CAP_W,
  localparam int DW             = aoit_pkg::DATA_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [aoit_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic [aoit_pkg::ACTION_W-1:0] action,
  input  logic [aoit_pkg::TXN_ID_W-1:0] txn_id,
  input  logic [DW-1:0]                 beat_data,
  input  logic                          last_beat,
  input  logic                          out_stall,
  input  aoit_pkg::ctrl_cmd_t           cmd,
  output aoit_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  output logic                          accepted,
  output logic [CNT_W-1:0]              writes_outstanding,
  output logic [CNT_W-1:0]              reads_outstanding,
  output logic                          data_found,
  output logic [DW-1:0]                 data_value
);

  // latched word
  aoit_pkg::action_t  action_q;
  logic [ID_BITS-1:0] id_q;
  logic [DW-1:0]      data_q;
  logic               last_q;

  logic [aoit_pkg::CAP_W-1:0] cap;
  logic [CMP_W-1:0]           cap_eff;

  logic [ID_BITS-1:0]         wr_ids [MAX_OUTSTANDING];
  logic [ID_BITS-1:0]         rd_ids [MAX_OUTSTANDING];
  logic [MAX_OUTSTANDING-1:0] wr_valid, rd_valid, wr_valid_next, rd_valid_next;
  logic [MAX_OUTSTANDING-1:0] wr_hit, rd_hit, wr_hit_1h, rd_hit_1h, wr_free_1h, rd_free_1h;
  logic [CNT_W-1:0]           wr_count, rd_count, wr_count_next, rd_count_next;
  logic                       wr_load, rd_load;

  logic [ID_BITS-1:0] sweep_addr;
  logic               ram_we;
  logic [ID_BITS-1:0] ram_waddr, ram_raddr;
  logic [DW:0]        ram_wdata, ram_rdata;
  logic               beat_we;

  logic               ok, found;
  logic [DW-1:0]      value;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q <= aoit_pkg::action_t'(action);
      id_q     <= ID_BITS'(txn_id);
      data_q   <= beat_data;
      last_q   <= last_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= aoit_pkg::CAP_W'(aoit_pkg::CAP_RESET);
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  always_comb begin
    cap_eff = CMP_W'(cap);
    if (cap == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(MAX_OUTSTANDING)) begin
      cap_eff = CMP_W'(MAX_OUTSTANDING);
    end
  end

  // parallel ID compare, then lowest hit and lowest free slot
  always_comb begin
    for (int i = 0; i < MAX_OUTSTANDING; i++) begin
      wr_hit[i] = wr_valid[i] && (wr_ids[i] == id_q);
      rd_hit[i] = rd_valid[i] && (rd_ids[i] == id_q);
    end
  end

  assign wr_hit_1h  = wr_hit & (~wr_hit + MAX_OUTSTANDING'(1));
  assign rd_hit_1h  = rd_hit & (~rd_hit + MAX_OUTSTANDING'(1));
  assign wr_free_1h = ~wr_valid & (wr_valid + MAX_OUTSTANDING'(1));
  assign rd_free_1h = ~rd_valid & (rd_valid + MAX_OUTSTANDING'(1));

  always_comb begin
    wr_valid_next = wr_valid;
    rd_valid_next = rd_valid;
    wr_count_next = wr_count;
    rd_count_next = rd_count;
    wr_load       = 1'b0;
    rd_load       = 1'b0;
    beat_we       = 1'b0;
    ok            = 1'b0;
    found         = 1'b0;
    value         = '0;
    unique case (action_q)
      aoit_pkg::ACT_ISSUE_WR: begin
        if (CMP_W'(wr_count) < cap_eff) begin
          wr_valid_next = wr_valid | wr_free_1h;
          wr_count_next = wr_count + CNT_W'(1);
          wr_load       = 1'b1;
          ok            = 1'b1;
        end
      end
      aoit_pkg::ACT_ISSUE_RD: begin
        if (CMP_W'(rd_count) < cap_eff) begin
          rd_valid_next = rd_valid | rd_free_1h;
          rd_count_next = rd_count + CNT_W'(1);
          rd_load       = 1'b1;
          ok            = 1'b1;
        end
      end
      aoit_pkg::ACT_CMPL_WR: begin
        if (|wr_hit) begin
          wr_valid_next = wr_valid & ~wr_hit_1h;
          wr_count_next = wr_count - CNT_W'(1);
          ok            = 1'b1;
        end
      end
      aoit_pkg::ACT_READ_BEAT: begin
        if (|rd_hit) begin
          beat_we = 1'b1;
          ok      = 1'b1;
          if (last_q) begin
            rd_valid_next = rd_valid & ~rd_hit_1h;
            rd_count_next = rd_count - CNT_W'(1);
          end
        end
      end
      aoit_pkg::ACT_LOOKUP: begin
        found = ram_rdata[DW];
        value = found ? ram_rdata[DW-1:0] : '0;
        ok    = found;
      end
      aoit_pkg::ACT_CLEAR: begin
        wr_valid_next = '0;
        rd_valid_next = '0;
        wr_count_next = '0;
        rd_count_next = '0;
        ok            = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= '0;
      rd_valid <= '0;
      wr_count <= '0;
      rd_count <= '0;
    end else if (cmd.exec) begin
      wr_valid <= wr_valid_next;
      rd_valid <= rd_valid_next;
      wr_count <= wr_count_next;
      rd_count <= rd_count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_OUTSTANDING; i++) begin
      if (cmd.exec && wr_load && wr_free_1h[i]) wr_ids[i] <= id_q;
      if (cmd.exec && rd_load && rd_free_1h[i]) rd_ids[i] <= id_q;
    end
  end

  // data store: {present, data} per ID, zeroed by the sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_addr + ID_BITS'(1);
    end
  end

  assign ram_we    = cmd.sweep || (cmd.exec && beat_we);
  assign ram_waddr = cmd.sweep ? sweep_addr : id_q;
  assign ram_wdata = cmd.sweep ? '0 : {1'b1, data_q};
  assign ram_raddr = cmd.capture ? ID_BITS'(txn_id) : id_q;

  aoit_ram #(
    .WIDTH (DW + 1),
    .DEPTH (1 << ID_BITS)
  ) u_data_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      accepted           <= ok;
      writes_outstanding <= wr_count_next;
      reads_outstanding  <= rd_count_next;
      data_found         <= found;
      data_value         <= value;
    end
  end

  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.is_clear   = (action_q == aoit_pkg::ACT_CLEAR);
  assign stat.sweep_last = &sweep_addr;

`ifndef SYNTH
  a_wr_count: assert property (@(posedge clk) disable iff (rst)
    wr_count == CNT_W'($countones(wr_valid)))
    else $error("write count out of step with write slots");
  a_rd_count: assert property (@(posedge clk) disable iff (rst)
    rd_count == CNT_W'($countones(rd_valid)))
    else $error("read count out of step with read slots");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!out_valid || !out_stall))
    else $error("result register loaded while a word is still held");
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(wr_hit_1h) && $onehot0(rd_hit_1h))
    else $error("more than one slot selected");
`endif

endmodule

[rtl/axi_outstanding_id_tracker_unit.sv]
// Top level of the AXI outstanding ID tracker.
`timescale 1ns / 1ps
//
// channel | handshake                 | word
// --------+---------------------------+--------------------------------------------
// in      | in_valid / in_stall       | action, txn_id, beat_data, last_beat
// out     | out_valid / out_stall     | accepted, writes_outstanding,
//         |                           | reads_outstanding, data_found, data_value
// cfg     | cfg_we / cfg_wdata        | capacity (5 bits, no read-back)
//
// Each word is first accepted, which addresses the data store, and then
// executed, which reads the store, matches the ID pools and loads the result
// register; the registered read of the per-ID data store keeps these apart.
// After reset and after a clear, a sweep zeroes all 2**ID_BITS entries of the
// data store (256 at default) at one entry a cycle, with in_stall high.
// The result register lets a word be accepted while the previous result
// waits; execution holds only while that register is full and stalled.
// cfg writes are taken on any cycle and must be issued while idle.

module axi_outstanding_id_tracker_unit #(
  parameter int MAX_OUTSTANDING = aoit_pkg::MAX_OUTSTANDING_DEF,
  parameter int ID_BITS         = aoit_pkg::ID_BITS_DEF,
  localparam int CNT_W          = $clog2(MAX_OUTSTANDING + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [aoit_pkg::CAP_W-1:0]    cfg_wdata,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aoit_pkg::ACTION_W-1:0] action,
  input  logic [aoit_pkg::TXN_ID_W-1:0] txn_id,
  input  logic [aoit_pkg::DATA_W-1:0]   beat_data,
  input  logic                          last_beat,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic [CNT_W-1:0]              writes_outstanding,
  output logic [CNT_W-1:0]              reads_outstanding,
  output logic                          data_found,
  output logic [aoit_pkg::DATA_W-1:0]   data_value
);

  aoit_pkg::ctrl_cmd_t cmd;
  aoit_pkg::dp_stat_t  stat;

  // state machine: sweep, wait for a word, execute it
  aoit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // pools, counters, data store and the result register
  aoit_dpath #(
    .MAX_OUTSTANDING (MAX_OUTSTANDING),
    .ID_BITS         (ID_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .action             (action),
    .txn_id             (txn_id),
    .beat_data          (beat_data),
    .last_beat          (last_beat),
    .out_stall          (out_stall),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .accepted           (accepted),
    .writes_outstanding (writes_outstanding),
    .reads_outstanding  (reads_outstanding),
    .data_found         (data_found),
    .data_value         (data_value)
  );

endmodule

[tb/axi_outstanding_id_tracker_unit_test.sv]
// Self-checking testbench for the AXI outstanding ID tracker unit.
`timescale 1ns / 1ps

module axi_outstanding_id_tracker_unit_test;
  import aoit_pkg::*;

  // Codes 6 and 7 are outside action_t; the block must ignore them.
  localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

  // Pool selectors for the predictor's slot arrays.
  localparam int WR_POOL = 0;
  localparam int RD_POOL = 1;

  localparam int SLOTS      = MAX_OUTSTANDING_DEF;
  localparam int ID_SPACE   = 1 << ID_BITS_DEF;
  localparam int CYCLE_CAP  = 300_000;
  localparam int HOLD_LEN   = 150;      // long receiver hold-off, in cycles

  // One expected result word.
  typedef struct packed {
    logic                  accepted;
    logic [CAP_W-1:0]      writes;
    logic [CAP_W-1:0]      reads;
    logic                  found;
    logic [DATA_W-1:0]     value;
  } tracker_result_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input starts known, reset is high from time zero.
  // ---------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] action = '0;
  logic [TXN_ID_W-1:0] txn_id = '0;
  logic [DATA_W-1:0]   beat_data = '0;
  logic                last_beat = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                accepted;
  logic [CAP_W-1:0]    writes_outstanding;
  logic [CAP_W-1:0]    reads_outstanding;
  logic                data_found;
  logic [DATA_W-1:0]   data_value;

  axi_outstanding_id_tracker_unit dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .txn_id             (txn_id),
    .beat_data          (beat_data),
    .last_beat          (last_beat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .accepted           (accepted),
    .writes_outstanding (writes_outstanding),
    .reads_outstanding  (reads_outstanding),
    .data_found         (data_found),
    .data_value         (data_value)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shared state of the bench.
  // ---------------------------------------------------------------------------
  tracker_result_t expected_results[$];  // one per accepted input word, in order
  int  mismatches   = 0;
  int  results_seen = 0;
  int  cycles       = 0;
  int  snd_idle_pct = 0;  // chance per cycle that the sender holds off
  int  rcv_idle_pct = 0;  // chance per cycle that the receiver stalls
  bit  hold_req     = 1'b0;
  int  hold_left    = 0;

  // Predictor copy of the tracker: two slot pools plus the per-ID data store.
  logic [TXN_ID_W-1:0] pool_id   [2][SLOTS];
  bit                  pool_live [2][SLOTS];
  logic [DATA_W-1:0]   rd_store  [ID_SPACE];
  bit                  rd_present[ID_SPACE];
  logic [CAP_W-1:0]    cap_reg = 5'(CAP_RESET);

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // zero acts as one, anything past the slot count saturates
  function automatic int eff_capacity();
    int c;
    c = int'(cap_reg);
    if (c == 0) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  function automatic int live_count(int p);
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (pool_live[p][i]) n++;
    return n;
  endfunction

  // lowest live slot holding this ID, -1 if none
  function automatic int find_slot(int p, logic [TXN_ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (pool_live[p][i] && pool_id[p][i] == id) return i;
    return -1;
  endfunction

  function automatic bit claim_slot(int p, logic [TXN_ID_W-1:0] id);
    if (live_count(p) >= eff_capacity()) return 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!pool_live[p][i]) begin
        pool_live[p][i] = 1'b1;
        pool_id[p][i]   = id;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic tracker_result_t predict_tracker(logic [ACTION_W-1:0] act,
                                                      logic [TXN_ID_W-1:0] id,
                                                      logic [DATA_W-1:0] data,
                                                      logic last);
    tracker_result_t r;
    int slot;
    r = '0;
    case (act)
      ACT_ISSUE_WR: begin
        r.accepted = claim_slot(WR_POOL, id);
      end
      ACT_ISSUE_RD: begin
        r.accepted = claim_slot(RD_POOL, id);
      end
      ACT_CMPL_WR: begin
        slot = find_slot(WR_POOL, id);
        if (slot >= 0) begin
          pool_live[WR_POOL][slot] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      ACT_READ_BEAT: begin
        // data lands on every matching beat; only the last beat frees the slot
        slot = find_slot(RD_POOL, id);
        if (slot >= 0) begin
          rd_store[id]   = data;
          rd_present[id] = 1'b1;
          if (last) pool_live[RD_POOL][slot] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (rd_present[id]) begin
          r.found = 1'b1;
          r.value = rd_store[id];
        end
        r.accepted = r.found;
      end
      ACT_CLEAR: begin
        // capacity survives a clear
        pool_live  = '{default: 1'b0};
        rd_present = '{default: 1'b0};
        r.accepted = 1'b1;
      end
      default: ;  // reserved codes change nothing
    endcase
    r.writes = CAP_W'(live_count(WR_POOL));
    r.reads  = CAP_W'(live_count(RD_POOL));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: one line per mismatch, counted.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("MISMATCH result %0d %s: got %0h, want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // Samples in the active region at the edge, so it sees the pre-edge values
  // of both the DUT outputs and the bench-driven stall.
  always @(posedge clk) begin : check_results
    tracker_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("word with nothing outstanding", DATA_W'(accepted), '0);
      end else begin
        want = expected_results.pop_front();
        if (accepted !== want.accepted)
          report_mismatch("accepted", DATA_W'(accepted), DATA_W'(want.accepted));
        if (writes_outstanding !== want.writes)
          report_mismatch("writes_outstanding", DATA_W'(writes_outstanding),
                          DATA_W'(want.writes));
        if (reads_outstanding !== want.reads)
          report_mismatch("reads_outstanding", DATA_W'(reads_outstanding),
                          DATA_W'(want.reads));
        if (data_found !== want.found)
          report_mismatch("data_found", DATA_W'(data_found), DATA_W'(want.found));
        if (data_value !== want.value)
          report_mismatch("data_value", data_value, want.value);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off counted here when requested.
  // One nonblocking write of out_stall per edge.
  // ---------------------------------------------------------------------------
  initial forever begin
    @(posedge clk);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Watchdog.
  initial begin
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("axi_outstanding_id_tracker_unit_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one word, holds it until taken, then predicts its result.
  // Called and returns at a rising edge.
  task automatic send_word(logic [ACTION_W-1:0] act, logic [TXN_ID_W-1:0] id,
                           logic [DATA_W-1:0] data, logic last);
    tracker_result_t want;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    txn_id    <= id;
    beat_data <= data;
    last_beat <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_tracker(act, id, data, last);
    expected_results = {expected_results, want};
  endtask

  // Drop valid and wait for every outstanding result word.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Capacity is only written while the block is idle.
  task automatic set_capacity(logic [CAP_W-1:0] v);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_reg = v;
  endtask

  // Mostly a few hot IDs so duplicates and matches happen; some full range.
  function automatic logic [TXN_ID_W-1:0] random_id();
    if ($urandom_range(0, 2) == 0) return TXN_ID_W'($urandom_range(0, 255));
    return ($urandom_range(0, 1) ? 8'hFC : 8'h00) | TXN_ID_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [TXN_ID_W-1:0] live_or_random(int p);
    logic [TXN_ID_W-1:0] ids[$];
    for (int i = 0; i < SLOTS; i++) if (pool_live[p][i]) ids = {ids, pool_id[p][i]};
    if (ids.size() == 0) return random_id();
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function automatic logic [TXN_ID_W-1:0] present_or_random();
    logic [TXN_ID_W-1:0] ids[$];
    for (int i = 0; i < ID_SPACE; i++) if (rd_present[i]) ids = {ids, TXN_ID_W'(i)};
    if (ids.size() == 0) return random_id();
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // Mostly well-formed traffic: completions and beats usually hit a live ID,
  // lookups usually hit recorded data. Rare clears, reserved codes as noise.
  task automatic send_random_word();
    logic [ACTION_W-1:0] act;
    logic [TXN_ID_W-1:0] id;
    logic [DATA_W-1:0]   data;
    logic                last;
    int                  sel;
    sel  = $urandom_range(0, 99);
    id   = random_id();
    data = {$urandom, $urandom};
    last = ($urandom_range(0, 99) < 40);
    if (sel < 18) begin
      act = ACT_ISSUE_WR;
    end else if (sel < 36) begin
      act = ACT_ISSUE_RD;
    end else if (sel < 52) begin
      act = ACT_CMPL_WR;
      if ($urandom_range(0, 9) != 0) id = live_or_random(WR_POOL);
    end else if (sel < 78) begin
      act = ACT_READ_BEAT;
      if ($urandom_range(0, 9) != 0) id = live_or_random(RD_POOL);
    end else if (sel < 93) begin
      act = ACT_LOOKUP;
      if ($urandom_range(0, 9) < 7) id = present_or_random();
    end else if (sel < 94) begin
      act = ACT_CLEAR;
    end else if (sel < 97) begin
      act = (sel == 94) ? ACT_RSVD6 : ACT_RSVD7;
    end else begin
      act = ACTION_W'($urandom_range(0, 7));
    end
    send_word(act, id, data, last);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every action, ID extremes, data extremes, duplicates, unmatched
  // completions, mid-burst vs last beat, missing lookup, reserved codes, clear.
  task automatic test_directed();
    send_word(ACT_ISSUE_WR,  8'd0,   '0, 1'b0);
    send_word(ACT_ISSUE_WR,  8'd255, '1, 1'b1);
    send_word(ACT_ISSUE_WR,  8'd0,   '0, 1'b0);  // duplicate ID
    send_word(ACT_CMPL_WR,   8'd0,   '0, 1'b0);  // frees one of the two
    send_word(ACT_CMPL_WR,   8'd7,   '0, 1'b0);  // no match
    send_word(ACT_ISSUE_RD,  8'd255, '0, 1'b0);
    send_word(ACT_READ_BEAT, 8'd255, '1, 1'b0);  // mid-burst, slot kept
    send_word(ACT_LOOKUP,    8'd255, '0, 1'b0);
    send_word(ACT_READ_BEAT, 8'd255, '0, 1'b1);  // last beat frees the slot
    send_word(ACT_LOOKUP,    8'd255, '1, 1'b1);  // found, value zero
    send_word(ACT_READ_BEAT, 8'd255, 64'h5A5A_A5A5_0F0F_F0F0, 1'b1);  // no match
    send_word(ACT_LOOKUP,    8'd3,   '0, 1'b0);  // never recorded
    send_word(ACT_RSVD6,     8'd255, '1, 1'b1);
    send_word(ACT_RSVD7,     8'd0,   '0, 1'b0);
    send_word(ACT_ISSUE_RD,  8'd0,   '0, 1'b0);
    send_word(ACT_READ_BEAT, 8'd0,   {$urandom, $urandom}, 1'b1);
    send_word(ACT_LOOKUP,    8'd0,   '0, 1'b0);
    send_word(ACT_CLEAR,     8'd255, '1, 1'b1);
    send_word(ACT_LOOKUP,    8'd255, '0, 1'b0);  // gone after clear
    send_word(ACT_CMPL_WR,   8'd255, '0, 1'b0);  // pool emptied by clear
  endtask

  // Capacity extremes: zero as one, saturation, lowering below the count.
  task automatic test_capacity();
    send_word(ACT_CLEAR, 8'd0, '0, 1'b0);
    set_capacity(5'd0);
    send_word(ACT_ISSUE_WR,  8'd10, '0, 1'b0);
    send_word(ACT_ISSUE_WR,  8'd11, '0, 1'b0);  // pool full at one
    send_word(ACT_ISSUE_RD,  8'd12, '0, 1'b0);
    send_word(ACT_ISSUE_RD,  8'd13, '0, 1'b0);
    send_word(ACT_CMPL_WR,   8'd10, '0, 1'b0);
    send_word(ACT_READ_BEAT, 8'd12, {$urandom, $urandom}, 1'b1);
    set_capacity(5'd31);
    for (int k = 0; k < SLOTS + 1; k++)  // last one refused
      send_word(ACT_ISSUE_WR, TXN_ID_W'(k * 15), {$urandom, $urandom}, 1'b0);
    // drop below the count: issues refused until the pool drains
    set_capacity(5'd1);
    send_word(ACT_ISSUE_WR, 8'd99, '0, 1'b0);
    for (int k = 0; k < SLOTS; k++)
      send_word(ACT_CMPL_WR, TXN_ID_W'(k * 15), '0, 1'b0);
    send_word(ACT_ISSUE_WR, 8'd99, '0, 1'b0);
    send_word(ACT_ISSUE_WR, 8'd98, '0, 1'b0);
    set_capacity(CAP_W'($urandom_range(2, 15)));
    send_word(ACT_CLEAR, 8'd0, '0, 1'b0);
  endtask

  task automatic test_random_traffic(int count, logic [CAP_W-1:0] cap);
    set_capacity(cap);
    for (int i = 0; i < count; i++) send_random_word();
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // result register fills and the block stalls its input.
  task automatic test_backpressure();
    quiesce();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_random_word();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // slow receiver
    snd_idle_pct = 27;
    rcv_idle_pct = 81;
    test_directed();
    test_capacity();
    test_random_traffic(350, CAP_W'($urandom_range(0, 31)));

    // slow sender
    snd_idle_pct = 81;
    rcv_idle_pct = 27;
    test_random_traffic(350, 5'd31);

    // full rate
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(350, 5'd16);
    test_backpressure();

    quiesce();
    repeat (10) @(posedge clk);  // catch stray words after the last one
    if (expected_results.size() != 0)
      report_mismatch("words never returned", DATA_W'(expected_results.size()), '0);

    if (mismatches == 0) begin
      $display("axi_outstanding_id_tracker_unit_test: clean");
    end else begin
      $display("axi_outstanding_id_tracker_unit_test: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/aoit_pkg.sv
rtl/aoit_ram.sv
rtl/aoit_ctrl.sv
rtl/aoit_dpath.sv
rtl/axi_outstanding_id_tracker_unit.sv
tb/axi_outstanding_id_tracker_unit_test.sv
